[sv/cft_pkg.sv]
// ----------------------------------------------------------------------------
// cft_pkg
// Shared types, character codes and helpers for the config file tokeniser.
// ----------------------------------------------------------------------------
package cft_pkg;

    typedef enum logic [1:0]
    {
        MODE_WORD    = 2'd0,
        MODE_COMMENT = 2'd1,
        MODE_QUOTED  = 2'd2
    } lex_mode_t;

    typedef enum logic [1:0]
    {
        KIND_BYTE    = 2'd0,
        KIND_END     = 2'd1,
        KIND_NEWLINE = 2'd2,
        KIND_PUNCT   = 2'd3
    } kind_t;

    typedef struct packed
    {
        logic [7:0] char_in;
        logic       end_marker;
    } in_beat_t;

    typedef struct packed
    {
        kind_t      kind;
        logic [7:0] byte_out;
        logic       last;
    } out_beat_t;

    // results of one input beat, at most two
    typedef struct packed
    {
        logic [1:0]      count;
        out_beat_t [1:0] beat;
    } lex_res_t;

    localparam logic [7:0] CH_TAB    = 8'h09;
    localparam logic [7:0] CH_CR     = 8'h0D;
    localparam logic [7:0] CH_NL     = 8'h0A;
    localparam logic [7:0] CH_SPACE  = 8'h20;
    localparam logic [7:0] CH_DQUOTE = 8'h22;
    localparam logic [7:0] CH_HASH   = 8'h23;
    localparam logic [7:0] CH_SQUOTE = 8'h27;
    localparam logic [7:0] CH_COMMA  = 8'h2C;
    localparam logic [7:0] CH_COLON  = 8'h3A;
    localparam logic [7:0] CH_SEMI   = 8'h3B;
    localparam logic [7:0] CH_EQ     = 8'h3D;
    localparam logic [7:0] CH_LBRK   = 8'h5B;
    localparam logic [7:0] CH_BSLASH = 8'h5C;
    localparam logic [7:0] CH_RBRK   = 8'h5D;

    localparam int Q_DEPTH = 4;
    localparam int Q_PTR_W = $clog2(Q_DEPTH);
    localparam int Q_CNT_W = $clog2(Q_DEPTH + 1);

    function automatic logic is_space(input logic [7:0] c);
        return (c == CH_SPACE) || ((c >= CH_TAB) && (c <= CH_CR));
    endfunction

    function automatic logic is_punct(input logic [7:0] c);
        return (c == CH_LBRK) || (c == CH_RBRK) || (c == CH_COMMA) ||
               (c == CH_EQ) || (c == CH_COLON) || (c == CH_SEMI);
    endfunction

    function automatic out_beat_t make_beat(input kind_t k, input logic [7:0] b);
        out_beat_t r;
        r.kind     = k;
        r.byte_out = b;
        r.last     = 1'b0;
        return r;
    endfunction

endpackage

[sv/cft_lexer.sv]
// ----------------------------------------------------------------------------
// cft_lexer
// Lexer state and the per-byte decision: up to two results per input beat.
// ----------------------------------------------------------------------------
module cft_lexer
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              fire,
    input  cft_pkg::in_beat_t in_beat,
    output cft_pkg::lex_res_t res
);
    import cft_pkg::*;

    lex_mode_t  mode_reg, mode_next;
    logic       quote_single_reg, quote_single_next;
    logic       word_pending_reg, word_pending_next;
    logic       nl_last_reg, nl_last_next;
    logic       prev_bs_reg, prev_bs_next;

    logic [7:0] c;
    logic [7:0] quote_ch;

    assign c        = in_beat.char_in;
    assign quote_ch = quote_single_reg ? CH_SQUOTE : CH_DQUOTE;

    // results
    always_comb
    begin
        res = '0;
        if (in_beat.end_marker)
        begin
            if ((mode_reg == MODE_QUOTED) ||
                ((mode_reg != MODE_COMMENT) && word_pending_reg))
            begin
                res.beat[0] = make_beat(KIND_END, 8'h00);
                res.count   = 2'd1;
            end
        end
        else
        begin
            case (mode_reg)
                MODE_COMMENT:
                begin
                    if ((c == CH_NL) && !nl_last_reg)
                    begin
                        res.beat[0] = make_beat(KIND_NEWLINE, 8'h00);
                        res.count   = 2'd1;
                    end
                end
                MODE_QUOTED:
                begin
                    if ((c == quote_ch) && !prev_bs_reg)
                        res.beat[0] = make_beat(KIND_END, 8'h00);
                    else
                        res.beat[0] = make_beat(KIND_BYTE, c);
                    res.count = 2'd1;
                end
                default:
                begin
                    if (is_space(c) || (c == CH_HASH) || (c == CH_SQUOTE) ||
                        (c == CH_DQUOTE) || is_punct(c))
                    begin
                        if (word_pending_reg)
                        begin
                            res.beat[0] = make_beat(KIND_END, 8'h00);
                            res.count   = 2'd1;
                        end
                        if ((c == CH_NL) && (word_pending_reg || !nl_last_reg))
                        begin
                            res.beat[res.count[0]] = make_beat(KIND_NEWLINE, 8'h00);
                            res.count              = res.count + 2'd1;
                        end
                        else if (is_punct(c))
                        begin
                            res.beat[res.count[0]] = make_beat(KIND_PUNCT, c);
                            res.count              = res.count + 2'd1;
                        end
                    end
                    else
                    begin
                        res.beat[0] = make_beat(KIND_BYTE, c);
                        res.count   = 2'd1;
                    end
                end
            endcase
        end
        if (res.count == 2'd2)
            res.beat[1].last = 1'b1;
        else if (res.count == 2'd1)
            res.beat[0].last = 1'b1;
    end

    // next state
    always_comb
    begin
        mode_next         = mode_reg;
        quote_single_next = quote_single_reg;
        word_pending_next = word_pending_reg;
        nl_last_next      = nl_last_reg;
        prev_bs_next      = prev_bs_reg;
        if (fire)
        begin
            if (in_beat.end_marker)
            begin
                mode_next         = MODE_WORD;
                quote_single_next = 1'b0;
                word_pending_next = 1'b0;
                nl_last_next      = 1'b0;
                prev_bs_next      = 1'b0;
            end
            else
            begin
                case (mode_reg)
                    MODE_COMMENT:
                    begin
                        if (c == CH_NL)
                            mode_next = MODE_WORD;
                    end
                    MODE_QUOTED:
                    begin
                        if ((c == quote_ch) && !prev_bs_reg)
                        begin
                            mode_next    = MODE_WORD;
                            prev_bs_next = 1'b0;
                        end
                        else
                            prev_bs_next = (c == CH_BSLASH);
                    end
                    default:
                    begin
                        mode_next = MODE_WORD;
                        if (is_space(c) || is_punct(c))
                            word_pending_next = 1'b0;
                        else if (c == CH_HASH)
                        begin
                            word_pending_next = 1'b0;
                            mode_next         = MODE_COMMENT;
                        end
                        else if ((c == CH_SQUOTE) || (c == CH_DQUOTE))
                        begin
                            word_pending_next = 1'b0;
                            mode_next         = MODE_QUOTED;
                            quote_single_next = (c == CH_SQUOTE);
                            prev_bs_next      = 1'b0;
                        end
                        else
                            word_pending_next = 1'b1;
                    end
                endcase
                // newline flag follows the final token emitted
                if (res.count != 2'd0)
                begin
                    case (res.beat[res.count[1]].kind)
                        KIND_NEWLINE: nl_last_next = 1'b1;
                        KIND_END:     nl_last_next = 1'b0;
                        KIND_PUNCT:   nl_last_next = 1'b0;
                        default:      nl_last_next = nl_last_reg;
                    endcase
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg         <= MODE_WORD;
            quote_single_reg <= 1'b0;
            word_pending_reg <= 1'b0;
            nl_last_reg      <= 1'b0;
            prev_bs_reg      <= 1'b0;
        end
        else
        begin
            mode_reg         <= mode_next;
            quote_single_reg <= quote_single_next;
            word_pending_reg <= word_pending_next;
            nl_last_reg      <= nl_last_next;
            prev_bs_reg      <= prev_bs_next;
        end
    end

endmodule

[sv/cft_out_fifo.sv]
// ----------------------------------------------------------------------------
// cft_out_fifo
// Result queue: takes up to two beats per cycle, hands out one per cycle while tok_stall is low.
// ----------------------------------------------------------------------------
module cft_out_fifo
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               push,
    input  cft_pkg::lex_res_t  res,
    output logic               full,
    output logic               tok_valid,
    input  logic               tok_stall,
    output cft_pkg::out_beat_t tok_beat
);
    import cft_pkg::*;

    out_beat_t          q_reg [Q_DEPTH];
    logic [Q_PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [Q_PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [Q_CNT_W-1:0] count_reg, count_next;
    logic [1:0]         push_n;
    logic               pop;

    assign push_n    = push ? res.count : 2'd0;
    assign pop       = tok_valid && !tok_stall;
    assign tok_valid = (count_reg != '0);
    assign tok_beat  = q_reg[rd_ptr_reg];
    // room for two more beats is needed before taking a byte
    assign full      = (count_reg > Q_CNT_W'(Q_DEPTH - 2));

    assign wr_ptr_next = wr_ptr_reg + Q_PTR_W'(push_n);
    assign rd_ptr_next = rd_ptr_reg + Q_PTR_W'(pop);
    assign count_next  = count_reg + Q_CNT_W'(push_n) - Q_CNT_W'(pop);

    always_ff @(posedge clk)
    begin
        if (push_n != 2'd0)
            q_reg[wr_ptr_reg] <= res.beat[0];
        if (push_n == 2'd2)
            q_reg[wr_ptr_reg + Q_PTR_W'(1)] <= res.beat[1];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

[sv/config_file_tokenizer_top.sv]
// ----------------------------------------------------------------------------
// config_file_tokenizer_top
// Streaming tokeniser for configuration text, one byte beat in, token beats out.
// ----------------------------------------------------------------------------
// One byte beat is taken per cycle whenever the four-entry result queue has
// room for two beats; its results can leave from the next cycle on. Results
// leave at one beat per cycle while tok_stall is low, so the sustained rate is
// one byte per cycle while bytes give at most one result each, and a byte
// giving two (word end plus newline or punctuation) lowers it. The single
// output port draining the result queue sets that figure.
module config_file_tokenizer_top
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               byte_valid,
    output logic               byte_stall,
    input  cft_pkg::in_beat_t  byte_beat,
    output logic               tok_valid,
    input  logic               tok_stall,
    output cft_pkg::out_beat_t tok_beat
);
    import cft_pkg::*;

    lex_res_t res;
    logic     fire;
    logic     full;

    assign byte_stall = full;
    assign fire       = byte_valid && !full;

    cft_lexer u_lexer
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .fire    (fire),
        .in_beat (byte_beat),
        .res     (res)
    );

    cft_out_fifo u_fifo
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (fire),
        .res       (res),
        .full      (full),
        .tok_valid (tok_valid),
        .tok_stall (tok_stall),
        .tok_beat  (tok_beat)
    );

endmodule

[sv/cft_checker.sv]
// ----------------------------------------------------------------------------
// cft_checker
// Port-level checks for the tokeniser, bound to the top level.
// ----------------------------------------------------------------------------
module cft_checker
(
    input logic               clk,
    input logic               rst_n,
    input logic               byte_valid,
    input logic               byte_stall,
    input cft_pkg::in_beat_t  byte_beat,
    input logic               tok_valid,
    input logic               tok_stall,
    input cft_pkg::out_beat_t tok_beat
);
    import cft_pkg::*;

    // a held token beat stays put
    a_tok_hold: assert property (@(posedge clk) disable iff (!rst_n)
        tok_valid && tok_stall |=> tok_valid && $stable(tok_beat))
        else $error("token beat changed while stalled");

    // input only backs up behind queued results
    a_stall_needs_tok: assert property (@(posedge clk) disable iff (!rst_n)
        byte_stall |-> tok_valid)
        else $error("byte stall with empty result queue");

    a_stall_rise: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(byte_stall) |-> $past(tok_valid))
        else $error("stall rose from an empty queue");

    a_zero_byte: assert property (@(posedge clk) disable iff (!rst_n)
        tok_valid && ((tok_beat.kind == KIND_END) || (tok_beat.kind == KIND_NEWLINE))
        |-> (tok_beat.byte_out == 8'h00))
        else $error("end or newline token carries a byte");

endmodule

bind config_file_tokenizer_top cft_checker u_cft_checker (.*);
